>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tdma_wt assertion failed");

// expr must never be true at a clock edge.
`define ASSERT_NEVER(label, expr) \
	`ASSERT_CLK(label, !(expr))

`endif

>>> rtl/tdma_wt_pkg.sv
package tdma_wt_pkg;

	localparam int WIN_W    = 16;
	localparam int LEN_W    = 18;
	localparam int LEFT_W   = 19;
	localparam int TIME_W   = 32;
	localparam int DIV_W    = 34;
	localparam int MAG_W    = 32;
	localparam int CNT_W    = $clog2(MAG_W / 2);
	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 5;
	localparam int APB_W    = 32;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 2;

	localparam logic [WIN_W-1:0] DEF_PEER_WINDOW = 16'd1000;
	localparam logic [WIN_W-1:0] RST_OWN_WINDOW  = 16'd1000;
	localparam logic [WIN_W-1:0] RST_GAP_LENGTH  = 16'd100;
	localparam logic [WIN_W-1:0] RST_TAIL_LENGTH = 16'd100;
	localparam logic [WIN_W-1:0] RST_MIN_PEER    = 16'd0;
	localparam logic [WIN_W-1:0] RST_MAX_PEER    = 16'hFFFF;

	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CARRIER = 2'd2;

	localparam logic [2:0] REG_OWN_WINDOW  = 3'd0;
	localparam logic [2:0] REG_GAP_LENGTH  = 3'd1;
	localparam logic [2:0] REG_TAIL_LENGTH = 3'd2;
	localparam logic [2:0] REG_MIN_PEER    = 3'd3;
	localparam logic [2:0] REG_MAX_PEER    = 3'd4;

	typedef struct packed {
		logic [WIN_W-1:0] own_window;
		logic [WIN_W-1:0] gap_length;
		logic [WIN_W-1:0] tail_length;
		logic [WIN_W-1:0] min_peer_window;
		logic [WIN_W-1:0] max_peer_window;
	} cfg_t;

	typedef struct packed {
		logic latch_in;
		logic ld_peer;
		logic ld_origin;
		logic mod_start;
		logic sel_sync;
		logic left_one;
		logic ld_out;
		logic out_status;
		logic out_resync;
	} dp_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic win_in_ok;
		logic peer_ok;
		logic peer_expired;
		logic out_busy;
	} dp_sts_t;

endpackage

>>> rtl/tdma_wt_regs.sv
module tdma_wt_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tdma_wt_pkg::ADDR_W-1:0]    paddr,
	input  logic [tdma_wt_pkg::APB_W-1:0]     pwdata,
	output logic [tdma_wt_pkg::APB_W-1:0]     prdata,
	output logic                              pready,
	output tdma_wt_pkg::cfg_t                 cfg
);
	import tdma_wt_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_window      <= RST_OWN_WINDOW;
			cfg_q.gap_length      <= RST_GAP_LENGTH;
			cfg_q.tail_length     <= RST_TAIL_LENGTH;
			cfg_q.min_peer_window <= RST_MIN_PEER;
			cfg_q.max_peer_window <= RST_MAX_PEER;
		end else if (wr_en) begin
			unique case (idx)
				REG_OWN_WINDOW:  cfg_q.own_window      <= pwdata[WIN_W-1:0];
				REG_GAP_LENGTH:  cfg_q.gap_length      <= pwdata[WIN_W-1:0];
				REG_TAIL_LENGTH: cfg_q.tail_length     <= pwdata[WIN_W-1:0];
				REG_MIN_PEER:    cfg_q.min_peer_window <= pwdata[WIN_W-1:0];
				REG_MAX_PEER:    cfg_q.max_peer_window <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_OWN_WINDOW:  prdata = APB_W'(cfg_q.own_window);
			REG_GAP_LENGTH:  prdata = APB_W'(cfg_q.gap_length);
			REG_TAIL_LENGTH: prdata = APB_W'(cfg_q.tail_length);
			REG_MIN_PEER:    prdata = APB_W'(cfg_q.min_peer_window);
			REG_MAX_PEER:    prdata = APB_W'(cfg_q.max_peer_window);
			default:         prdata = '0;
		endcase
	end

endmodule

>>> rtl/tdma_wt_mod.sv
module tdma_wt_mod (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tdma_wt_pkg::DIV_W-1:0]   dividend,
	input  logic [tdma_wt_pkg::LEN_W-1:0]   modulus,
	output logic                            done,
	output logic [tdma_wt_pkg::LEN_W-1:0]   result
);
	import tdma_wt_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W / 2 - 1);

	// restoring remainder step, one dividend bit
	function automatic logic [LEN_W-1:0] rem_step(input logic [LEN_W-1:0] r,
			input logic b, input logic [LEN_W-1:0] m);
		logic [LEN_W:0] t;
		t = {r, b};
		if (t >= {1'b0, m})
			t = t - {1'b0, m};
		return t[LEN_W-1:0];
	endfunction

	logic             busy_q;
	logic             fin_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [MAG_W-1:0] mag_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] result_q;
	logic [DIV_W-1:0] neg_div;
	logic [LEN_W-1:0] rem_a;
	logic [LEN_W-1:0] rem_b;
	logic [LEN_W-1:0] rem_fin;

	assign neg_div = -dividend;
	assign rem_a   = rem_step(rem_q, mag_q[MAG_W-1], modulus);
	assign rem_b   = rem_step(rem_a, mag_q[MAG_W-2], modulus);

	// floor modulo: a nonzero remainder of a negative value folds to L - r
	always_comb begin
		if (modulus == '0)
			rem_fin = '0;
		else if (neg_q && rem_q != '0)
			rem_fin = modulus - rem_q;
		else
			rem_fin = rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIV_W-1];
			mag_q <= dividend[DIV_W-1] ? neg_div[MAG_W-1:0] : dividend[MAG_W-1:0];
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[MAG_W-3:0], 2'b00};
			rem_q <= rem_b;
		end
		if (fin_q)
			result_q <= rem_fin;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/tdma_wt_dp.sv
module tdma_wt_dp #(
	parameter logic [tdma_wt_pkg::WIN_W-1:0] DEFAULT_WINDOW = tdma_wt_pkg::DEF_PEER_WINDOW
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tdma_wt_pkg::cfg_t                cfg,
	input  logic [tdma_wt_pkg::TIME_W-1:0]   now_time,
	input  logic [tdma_wt_pkg::WIN_W-1:0]    peer_window_in,
	input  logic [tdma_wt_pkg::WIN_W-1:0]    peer_left_in,
	input  tdma_wt_pkg::dp_cmd_t             cmd,
	output tdma_wt_pkg::dp_sts_t             sts,
	input  logic                             m_tready,
	output logic                             out_valid,
	output logic                             out_status,
	output logic                             out_resync,
	output logic                             out_can_send,
	output logic [tdma_wt_pkg::LEFT_W-1:0]   out_own_left,
	output logic [tdma_wt_pkg::LEFT_W-1:0]   out_peer_left,
	output logic [tdma_wt_pkg::WIN_W-1:0]    out_stamp_window,
	output logic [tdma_wt_pkg::WIN_W-1:0]    out_stamp_left
);
	import tdma_wt_pkg::*;

	logic [TIME_W-1:0] now_q;
	logic [WIN_W-1:0]  win_in_q;
	logic [WIN_W-1:0]  left_in_q;
	logic [WIN_W-1:0]  peer_q;
	logic [LEN_W-1:0]  origin_q;
	logic              out_valid_q;

	logic [LEN_W-1:0]  cyc_len;
	logic [WIN_W:0]    own_gap;
	logic [DIV_W-1:0]  now_x;
	logic [WIN_W-1:0]  left_sel;
	logic [DIV_W-1:0]  dividend;
	logic              mod_done;
	logic [LEN_W-1:0]  mod_res;
	logic [LEFT_W-1:0] own_left;
	logic [LEN_W+1:0]  peer_diff;
	logic [LEN_W+1:0]  peer_wrap;
	logic [LEFT_W-1:0] peer_left;

	assign cyc_len = LEN_W'(cfg.own_window) + LEN_W'(cfg.gap_length)
		+ LEN_W'(peer_q) + LEN_W'(cfg.tail_length);
	assign own_gap = (WIN_W + 1)'(cfg.own_window) + (WIN_W + 1)'(cfg.gap_length);

	assign now_x    = {{(DIV_W - TIME_W){now_q[TIME_W-1]}}, now_q};
	assign left_sel = cmd.left_one ? WIN_W'(1) : left_in_q;
	assign dividend = cmd.sel_sync
		? now_x + DIV_W'(left_sel) + DIV_W'(cfg.tail_length)
		: now_x - DIV_W'(origin_q);

	tdma_wt_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (dividend),
		.modulus  (cyc_len),
		.done     (mod_done),
		.result   (mod_res)
	);

	// mod_res is (now - origin) mod L; peer offset follows with one fold
	assign own_left  = LEFT_W'(cfg.own_window) - LEFT_W'(mod_res);
	assign peer_diff = (LEN_W + 2)'(mod_res) - (LEN_W + 2)'(own_gap);
	assign peer_wrap = peer_diff[LEN_W+1] ? peer_diff + (LEN_W + 2)'(cyc_len) : peer_diff;
	assign peer_left = LEFT_W'(peer_q) - LEFT_W'(peer_wrap[LEN_W-1:0]);

	assign sts.mod_done     = mod_done;
	assign sts.win_in_ok    = win_in_q >= cfg.min_peer_window && win_in_q <= cfg.max_peer_window;
	assign sts.peer_ok      = peer_q >= cfg.min_peer_window && peer_q <= cfg.max_peer_window;
	assign sts.peer_expired = peer_left[LEFT_W-1] || peer_left == '0;
	assign sts.out_busy     = out_valid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_q      <= DEFAULT_WINDOW;
			origin_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_peer)
				peer_q <= win_in_q;
			if (cmd.ld_origin)
				origin_q <= mod_res;
			if (cmd.ld_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			now_q     <= now_time;
			win_in_q  <= peer_window_in;
			left_in_q <= peer_left_in;
		end
		if (cmd.ld_out) begin
			out_status       <= cmd.out_status;
			out_resync       <= cmd.out_resync;
			out_can_send     <= !own_left[LEFT_W-1] && own_left != '0;
			out_own_left     <= own_left;
			out_peer_left    <= peer_left;
			out_stamp_window <= cfg.own_window;
			out_stamp_left   <= own_left[WIN_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/tdma_wt_ctrl.sv
module tdma_wt_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tdma_wt_pkg::CMD_W-1:0]   command,
	input  tdma_wt_pkg::dp_sts_t            sts,
	output tdma_wt_pkg::dp_cmd_t            cmd
);
	import tdma_wt_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_CHECK     = 3'd1;
	localparam logic [2:0] ST_SYNC_GO   = 3'd2;
	localparam logic [2:0] ST_SYNC_WAIT = 3'd3;
	localparam logic [2:0] ST_OWN_GO    = 3'd4;
	localparam logic [2:0] ST_OWN_WAIT  = 3'd5;
	localparam logic [2:0] ST_OUT       = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [CMD_W-1:0] cmd_q;
	logic             status_q, status_d;
	logic             resync_q, resync_d;
	logic             checked_q, checked_d;
	logic             accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d   = state_q;
		status_d  = status_q;
		resync_d  = resync_q;
		checked_d = checked_q;
		cmd       = '0;
		cmd.latch_in   = accept;
		cmd.out_status = status_q;
		cmd.out_resync = resync_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					status_d  = 1'b0;
					resync_d  = 1'b0;
					checked_d = 1'b0;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (cmd_q == CMD_FRAME) begin
					if (sts.win_in_ok) begin
						cmd.ld_peer = 1'b1;
						state_d     = ST_SYNC_GO;
					end else begin
						status_d = 1'b1;
						state_d  = ST_OWN_GO;
					end
				end else begin
					state_d = ST_OWN_GO;
				end
			end
			ST_SYNC_GO: begin
				cmd.mod_start = 1'b1;
				cmd.sel_sync  = 1'b1;
				cmd.left_one  = resync_q;
				state_d       = ST_SYNC_WAIT;
			end
			ST_SYNC_WAIT: begin
				if (sts.mod_done) begin
					cmd.ld_origin = 1'b1;
					state_d       = ST_OWN_GO;
				end
			end
			ST_OWN_GO: begin
				cmd.mod_start = 1'b1;
				state_d       = ST_OWN_WAIT;
			end
			ST_OWN_WAIT: begin
				if (sts.mod_done) begin
					state_d = ST_OUT;
					// carrier sensed: first pass decides on a resync
					if (cmd_q == CMD_CARRIER && !checked_q) begin
						checked_d = 1'b1;
						if (sts.peer_expired) begin
							resync_d = 1'b1;
							if (sts.peer_ok)
								state_d = ST_SYNC_GO;
							else
								status_d = 1'b1;
						end
					end
				end
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= CMD_QUERY;
			status_q  <= 1'b0;
			resync_q  <= 1'b0;
			checked_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			status_q  <= status_d;
			resync_q  <= resync_d;
			checked_q <= checked_d;
			if (accept)
				cmd_q <= command;
		end
	end

endmodule

>>> rtl/tdma_window_timer.sv
// Two-party TDMA window timer. Each input word carries a command in s_tuser
// (query, peer frame received, carrier sensed) and a time in ms; each one
// gives exactly one output word with own and peer remaining window time,
// can-send and header stamp fields, taken after any update the command makes.
// Time differences are reduced modulo the cycle length by one shared serial
// remainder unit that retires two dividend bits per clock: a start step, the
// shift steps, a sign fold step and a done step per reduction, plus a state
// machine hand-off around each. A query, a rejected frame or a carrier sense
// without resync takes one reduction from accept to output valid; an accepted
// frame takes two; a carrier sense that resynchronizes takes three. The next
// word can be accepted in the cycle after the output register loads. One word
// is in flight at a time; the output register lets the next word be accepted
// while a result waits, and a word whose result is ready stalls until that
// register frees up. Registers sit on the APB port at 4*index.
module tdma_window_timer #(
	parameter logic [tdma_wt_pkg::WIN_W-1:0] DEFAULT_WINDOW = tdma_wt_pkg::DEF_PEER_WINDOW
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [tdma_wt_pkg::ADDR_W-1:0]        paddr,
	input  logic [tdma_wt_pkg::APB_W-1:0]         pwdata,
	output logic [tdma_wt_pkg::APB_W-1:0]         prdata,
	output logic                                  pready,
	// input words
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// now_time[31:0], peer_window_in[47:32], peer_left_in[63:48]
	input  logic [tdma_wt_pkg::IN_DATA_W-1:0]     s_tdata,
	// command[1:0]
	input  logic [tdma_wt_pkg::CMD_W-1:0]         s_tuser,
	// output words
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// can_send[0], own_left[19:1], peer_left[38:20], stamp_window[54:39],
	// stamp_left[70:55], zero[71]
	output logic [tdma_wt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status[0], carrier_resync[1]
	output logic [tdma_wt_pkg::OUT_USER_W-1:0]    m_tuser
);
	import tdma_wt_pkg::*;

	cfg_t              cfg;
	dp_cmd_t           dcmd;
	dp_sts_t           dsts;
	logic              out_status;
	logic              out_resync;
	logic              out_can_send;
	logic [LEFT_W-1:0] out_own_left;
	logic [LEFT_W-1:0] out_peer_left;
	logic [WIN_W-1:0]  out_stamp_window;
	logic [WIN_W-1:0]  out_stamp_left;

	tdma_wt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tdma_wt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.command  (s_tuser),
		.sts      (dsts),
		.cmd      (dcmd)
	);

	tdma_wt_dp #(
		.DEFAULT_WINDOW (DEFAULT_WINDOW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.now_time         (s_tdata[TIME_W-1:0]),
		.peer_window_in   (s_tdata[TIME_W+WIN_W-1:TIME_W]),
		.peer_left_in     (s_tdata[TIME_W+2*WIN_W-1:TIME_W+WIN_W]),
		.cmd              (dcmd),
		.sts              (dsts),
		.m_tready         (m_tready),
		.out_valid        (m_tvalid),
		.out_status       (out_status),
		.out_resync       (out_resync),
		.out_can_send     (out_can_send),
		.out_own_left     (out_own_left),
		.out_peer_left    (out_peer_left),
		.out_stamp_window (out_stamp_window),
		.out_stamp_left   (out_stamp_left)
	);

	assign m_tdata = {1'b0, out_stamp_left, out_stamp_window, out_peer_left,
		out_own_left, out_can_send};
	assign m_tuser = {out_resync, out_status};

endmodule

>>> rtl/tdma_wt_checker.sv
`include "assert_macros.svh"

module tdma_wt_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [tdma_wt_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic [tdma_wt_pkg::OUT_USER_W-1:0]    m_tuser
);

	`ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_CLK(a_one_word, s_tvalid && s_tready |=> !s_tready)
	`ASSERT_CLK(a_can_send, m_tvalid |-> m_tdata[0] == (!m_tdata[19] && m_tdata[19:1] != '0))
	`ASSERT_CLK(a_stamp_left, m_tvalid |-> m_tdata[70:55] == m_tdata[16:1])
	`ASSERT_NEVER(a_pad_bit, m_tvalid && m_tdata[71])

endmodule

bind tdma_window_timer tdma_wt_checker u_tdma_wt_checker (.*);

>>> dv/tdma_window_timer_tb.sv
module tdma_window_timer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tdma_wt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TIME_W-1:0] now;
		logic [WIN_W-1:0]  win;
		logic [WIN_W-1:0]  left;
	} evt_t;

	typedef struct packed {
		logic              status;
		logic              resync;
		logic              can_send;
		logic [LEFT_W-1:0] own_left;
		logic [LEFT_W-1:0] peer_left;
		logic [WIN_W-1:0]  stamp_window;
		logic [WIN_W-1:0]  stamp_left;
	} report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [APB_W-1:0]      pwdata = '0;
	logic [APB_W-1:0]      prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	tdma_window_timer i_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// timer model state
	cfg_t             cfg_m;
	logic [LEN_W-1:0] origin_m;
	logic [WIN_W-1:0] peer_win_m;

	evt_t    pending[$];
	evt_t    cur_evt;
	report_t report_q[$];
	report_t want_r;

	int          n_queued = 0;
	int          n_checked = 0;
	int          errors = 0;
	int          burst_cnt = 0;
	int          gap_cnt = 0;
	int          rdy_cnt = 0;
	logic        rdy_level = 1'b0;
	int          idle_cnt = 0;
	logic [31:0] clock_ms = '0;

	function automatic longint cyc_mod(longint d);
		longint len, r;
		len = longint'(cfg_m.own_window) + longint'(cfg_m.gap_length) +
			longint'(peer_win_m) + longint'(cfg_m.tail_length);
		if (len == 0)
			return 0;
		r = d % len;
		if (r < 0)
			r += len;
		return r;
	endfunction

	function automatic longint own_rem(longint now);
		return longint'(cfg_m.own_window) - cyc_mod(now - longint'(origin_m));
	endfunction

	function automatic longint peer_rem(longint now);
		longint start;
		start = longint'(origin_m) + longint'(cfg_m.own_window) + longint'(cfg_m.gap_length);
		return longint'(peer_win_m) - cyc_mod(now - start);
	endfunction

	// returns 1 when the announced length is out of range
	function automatic logic adopt_window(longint now, logic [WIN_W-1:0] len,
			logic [WIN_W-1:0] left);
		longint o;
		if (len < cfg_m.min_peer_window || len > cfg_m.max_peer_window)
			return 1'b1;
		peer_win_m = len;
		o = cyc_mod(now + longint'(left) + longint'(cfg_m.tail_length));
		origin_m = o[LEN_W-1:0];
		return 1'b0;
	endfunction

	function automatic report_t compute_report(evt_t e);
		longint  now, own_l, peer_l;
		report_t r;
		now = longint'($signed(e.now));
		r = '0;
		case (e.cmd)
		CMD_FRAME: begin
			r.status = adopt_window(now, e.win, e.left);
		end
		CMD_CARRIER: begin
			if (peer_rem(now) <= 0) begin
				r.resync = 1'b1;
				r.status = adopt_window(now, peer_win_m, 16'd1);
			end
		end
		default: ;
		endcase
		own_l = own_rem(now);
		peer_l = peer_rem(now);
		r.can_send = (own_l > 0);
		r.own_left = own_l[LEFT_W-1:0];
		r.peer_left = peer_l[LEFT_W-1:0];
		r.stamp_window = cfg_m.own_window;
		r.stamp_left = own_l[WIN_W-1:0];
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				report_q.push_back(compute_report(cur_evt));
			if (!s_tvalid || s_tready) begin
				if (gap_cnt > 0 || pending.size() == 0) begin
					if (gap_cnt > 0)
						gap_cnt--;
					s_tvalid <= 1'b0;
				end else begin
					cur_evt = pending.pop_front();
					s_tdata <= {cur_evt.left, cur_evt.win, cur_evt.now};
					s_tuser <= cur_evt.cmd;
					s_tvalid <= 1'b1;
					if (burst_cnt > 0) begin
						burst_cnt--;
					end else begin
						burst_cnt = $urandom_range(24, 1);
						case ($urandom_range(7))
						0: gap_cnt = $urandom_range(70, 20);
						1, 2: gap_cnt = 0;
						default: gap_cnt = $urandom_range(8, 1);
						endcase
					end
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// monitor and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (report_q.size() == 0) begin
				$display("%0t: unexpected output word, expected none actual tdata %0h tuser %0h",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want_r = report_q.pop_front();
				check_field("status", 32'(want_r.status), 32'(m_tuser[0]));
				check_field("carrier_resync", 32'(want_r.resync), 32'(m_tuser[1]));
				check_field("can_send", 32'(want_r.can_send), 32'(m_tdata[0]));
				check_field("own_left", 32'(want_r.own_left), 32'(m_tdata[19:1]));
				check_field("peer_left", 32'(want_r.peer_left), 32'(m_tdata[38:20]));
				check_field("stamp_window", 32'(want_r.stamp_window), 32'(m_tdata[54:39]));
				check_field("stamp_left", 32'(want_r.stamp_left), 32'(m_tdata[70:55]));
				n_checked++;
			end
		end
		if (rdy_cnt == 0) begin
			case ($urandom_range(3))
			0: begin
				rdy_level = 1'b1;
				rdy_cnt = $urandom_range(300, 50);
			end
			1: begin
				rdy_level = 1'b0;
				rdy_cnt = $urandom_range(40, 1);
			end
			default: begin
				rdy_level = 1'($urandom_range(1));
				rdy_cnt = $urandom_range(6, 1);
			end
			endcase
		end else begin
			rdy_cnt--;
		end
		m_tready <= rdy_level;
	end

	// watchdog: no word moving while results are outstanding
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || n_checked == n_queued) begin
			idle_cnt <= 0;
		end else if (idle_cnt == IDLE_LIMIT) begin
			$display("[tdma_window_timer] ERROR");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	task automatic push_evt(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now,
			logic [WIN_W-1:0] win, logic [WIN_W-1:0] left);
		evt_t e;
		e.cmd = cmd;
		e.now = now;
		e.win = win;
		e.left = left;
		pending.push_back(e);
		n_queued++;
	endtask

	task automatic wait_idle();
		while (n_checked != n_queued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [WIN_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= APB_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_OWN_WINDOW:  cfg_m.own_window = val;
		REG_GAP_LENGTH:  cfg_m.gap_length = val;
		REG_TAIL_LENGTH: cfg_m.tail_length = val;
		REG_MIN_PEER:    cfg_m.min_peer_window = val;
		REG_MAX_PEER:    cfg_m.max_peer_window = val;
		default: ;
		endcase
	endtask

	task automatic set_cfg(logic [WIN_W-1:0] own, logic [WIN_W-1:0] gap,
			logic [WIN_W-1:0] tail, logic [WIN_W-1:0] mn, logic [WIN_W-1:0] mx);
		wait_idle();
		write_reg(REG_OWN_WINDOW, own);
		write_reg(REG_GAP_LENGTH, gap);
		write_reg(REG_TAIL_LENGTH, tail);
		write_reg(REG_MIN_PEER, mn);
		write_reg(REG_MAX_PEER, mx);
	endtask

	task automatic random_phase(int count, int step_max);
		evt_t e;
		int   pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				clock_ms = clock_ms + $urandom_range(step_max);
				e.now = clock_ms;
			end else if (pick < 88) begin
				e.now = $urandom;
			end else begin
				case ($urandom_range(2))
				0: e.now = 32'h7FFF_FFFF - $urandom_range(64);
				1: e.now = 32'h8000_0000 + $urandom_range(64);
				default: e.now = 32'hFFFF_FFE0 + $urandom_range(63);
				endcase
			end
			pick = $urandom_range(99);
			if (pick < 38)
				e.cmd = CMD_QUERY;
			else if (pick < 63)
				e.cmd = CMD_FRAME;
			else if (pick < 95)
				e.cmd = CMD_CARRIER;
			else
				e.cmd = CMD_SPARE;
			if (cfg_m.min_peer_window <= cfg_m.max_peer_window && $urandom_range(4) != 0)
				e.win = 16'($urandom_range(cfg_m.max_peer_window, cfg_m.min_peer_window));
			else
				e.win = 16'($urandom);
			if ($urandom_range(4) != 0)
				e.left = 16'($urandom_range(e.win));
			else
				e.left = 16'($urandom);
			push_evt(e.cmd, e.now, e.win, e.left);
		end
	endtask

	initial begin
		cfg_m = '{RST_OWN_WINDOW, RST_GAP_LENGTH, RST_TAIL_LENGTH, RST_MIN_PEER, RST_MAX_PEER};
		origin_m = '0;
		peer_win_m = DEF_PEER_WINDOW;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: window edges, time extremes, both carrier outcomes
		push_evt(CMD_QUERY, 32'd0, 16'd0, 16'd0);
		push_evt(CMD_QUERY, 32'd999, 16'hFFFF, 16'hFFFF);
		push_evt(CMD_QUERY, 32'd1000, 16'd0, 16'd0);
		push_evt(CMD_QUERY, 32'h7FFF_FFFF, 16'd0, 16'd0);
		push_evt(CMD_QUERY, 32'h8000_0000, 16'd0, 16'd0);
		push_evt(CMD_QUERY, 32'hFFFF_FFFF, 16'd0, 16'd0);
		push_evt(CMD_CARRIER, 32'd500, 16'd0, 16'd0);
		push_evt(CMD_CARRIER, 32'd1800, 16'd0, 16'd0);
		push_evt(CMD_SPARE, 32'd777, 16'hFFFF, 16'hFFFF);
		push_evt(CMD_FRAME, 32'd0, 16'd1000, 16'd0);
		push_evt(CMD_FRAME, 32'h8000_0000, 16'hFFFF, 16'hFFFF);
		push_evt(CMD_FRAME, 32'd123456, 16'd1000, 16'd500);

		// bounds check on announced windows
		set_cfg(16'd1000, 16'd100, 16'd100, 16'd500, 16'd2000);
		push_evt(CMD_FRAME, 32'd10, 16'd499, 16'd0);
		push_evt(CMD_FRAME, 32'd20, 16'd2001, 16'd0);
		push_evt(CMD_FRAME, 32'd30, 16'd500, 16'd100);
		push_evt(CMD_FRAME, 32'd40, 16'd2000, 16'd0);
		push_evt(CMD_CARRIER, 32'd0, 16'd0, 16'd0);
		push_evt(CMD_CARRIER, 32'd1000, 16'd0, 16'd0);
		push_evt(CMD_CARRIER, 32'd3000, 16'd0, 16'd0);

		// resync attempt rejected by the range check
		set_cfg(16'd1000, 16'd100, 16'd100, 16'd3000, 16'd4000);
		push_evt(CMD_CARRIER, 32'd0, 16'd0, 16'd0);
		push_evt(CMD_CARRIER, 32'd1100, 16'd0, 16'd0);
		push_evt(CMD_CARRIER, 32'd2200, 16'd0, 16'd0);

		// zero cycle length
		set_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
		push_evt(CMD_FRAME, 32'd5, 16'd0, 16'd7);
		push_evt(CMD_QUERY, 32'd12345, 16'd0, 16'd0);
		push_evt(CMD_CARRIER, 32'd99, 16'd0, 16'd0);

		set_cfg(16'd20, 16'd5, 16'd5, 16'd10, 16'd40);
		random_phase(250, 30);
		set_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd3);
		random_phase(250, 8);
		set_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_phase(250, 200000);
		set_cfg(16'd300, 16'd50, 16'd50, 16'd100, 16'd1000);
		random_phase(250, 500);
		set_cfg(16'($urandom_range(200)), 16'($urandom_range(200)), 16'($urandom_range(200)),
			16'($urandom_range(200)), 16'($urandom_range(200)));
		random_phase(250, 200);
		set_cfg(16'd1, 16'd1, 16'd1, 16'd40000, 16'd30000);
		random_phase(250, 5);
		set_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		random_phase(250, 262140);

		wait_idle();
		if (errors == 0)
			$display("[tdma_window_timer] OK");
		else
			$display("[tdma_window_timer] ERROR");
		$finish;
	end

endmodule
